FILE: sv/sem_pkg.sv
// Package: shared types and constants for the Sobel edge magnitude unit.
package sem_pkg;

    localparam int unsigned MaxLinePixels = 1024;
    localparam logic [10:0] FrameWidthReset  = 11'd640;
    localparam logic [11:0] FrameHeightReset = 12'd480;
    localparam int unsigned CfgIndexWidth = 1;
    localparam logic [CfgIndexWidth-1:0] RegFrameWidth  = 1'b0;
    localparam logic [CfgIndexWidth-1:0] RegFrameHeight = 1'b1;
    localparam logic [16:0] RootClampLimit = 17'd65280;

    // one 3-row column of packed pixels, blue in bits 0-7
    typedef struct packed {
        logic [23:0] top;
        logic [23:0] mid;
        logic [23:0] bot;
    } column_t;

    // a window request handed to the magnitude unit
    typedef struct packed {
        column_t left;
        column_t center;
        column_t right;
        logic    last;
    } window_t;

    typedef enum logic [1:0] {
        ST_TAKE,
        ST_READ,
        ST_EMIT1,
        ST_EMIT2
    } seq_state_t;

endpackage

FILE: sv/sem_root.sv
// Rounded integer square root, one result bit per cycle, clamped to 255.
module sem_root
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [16:0] value,
    output logic        done,
    output logic [7:0]  root
);

    logic [16:0] value_reg, value_next;
    logic [7:0]  n_reg, n_next;
    logic [7:0]  bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        fin_reg, fin_next;
    logic [7:0]  root_reg, root_next;
    logic [7:0]  trial;
    logic [15:0] trial_sq;
    logic [15:0] n_sq;
    logic [17:0] nn_plus;

    assign trial    = n_reg | bit_reg;
    assign trial_sq = {8'd0, trial} * {8'd0, trial};
    assign n_sq     = {8'd0, n_reg} * {8'd0, n_reg};
    assign nn_plus  = {2'b0, n_sq} + {10'd0, n_reg};

    always_comb
    begin
        value_next = value_reg;
        n_next     = n_reg;
        bit_next   = bit_reg;
        busy_next  = busy_reg;
        fin_next   = 1'b0;
        root_next  = root_reg;
        if (start)
        begin
            value_next = value;
            n_next     = 8'd0;
            bit_next   = 8'h80;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (bit_reg != 8'd0)
            begin
                if ({1'b0, trial_sq} <= value_reg)
                    n_next = trial;
                bit_next = bit_reg >> 1;
            end
            else
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
                if (value_reg > sem_pkg::RootClampLimit)
                    root_next = 8'd255;
                else if ({1'b0, value_reg} > nn_plus)
                    root_next = (n_reg == 8'd255) ? 8'd255 : n_reg + 8'd1;
                else
                    root_next = n_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        n_reg     <= n_next;
        bit_reg   <= bit_next;
        root_reg  <= root_next;
    end

    assign done = fin_reg;
    assign root = root_reg;

endmodule

FILE: sv/sem_mag.sv
// Per-channel Sobel gradient and magnitude for one window request.
module sem_mag
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  sem_pkg::window_t win,
    output logic             done,
    output logic [23:0]      mag
);

    logic [2:0]  root_done;
    logic [16:0] sq_reg [3];
    logic        go_reg;

    function automatic logic [16:0] grad_sq(input sem_pkg::window_t w, input int sh);
        logic signed [11:0] gx;
        logic signed [11:0] gy;
        logic signed [23:0] s;
        gx = $signed({4'd0, w.right.top[sh+:8]}) + $signed({3'd0, w.right.mid[sh+:8], 1'b0})
           + $signed({4'd0, w.right.bot[sh+:8]}) - $signed({4'd0, w.left.top[sh+:8]})
           - $signed({3'd0, w.left.mid[sh+:8], 1'b0}) - $signed({4'd0, w.left.bot[sh+:8]});
        gy = $signed({4'd0, w.left.bot[sh+:8]}) + $signed({3'd0, w.center.bot[sh+:8], 1'b0})
           + $signed({4'd0, w.right.bot[sh+:8]}) - $signed({4'd0, w.left.top[sh+:8]})
           - $signed({3'd0, w.center.top[sh+:8], 1'b0}) - $signed({4'd0, w.right.top[sh+:8]});
        s = gx * gx + gy * gy;
        grad_sq = (s > 24'sd65281) ? 17'd65281 : s[16:0];
    endfunction

    always_ff @(posedge clk)
    begin
        sq_reg[0] <= grad_sq(win, 0);
        sq_reg[1] <= grad_sq(win, 8);
        sq_reg[2] <= grad_sq(win, 16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            go_reg <= 1'b0;
        else
            go_reg <= start;
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_root
        sem_root u_root
        (
            .clk   (clk),
            .rst_n (rst_n),
            .start (go_reg),
            .value (sq_reg[k]),
            .done  (root_done[k]),
            .root  (mag[8*k +: 8])
        );
    end

    // the three roots run in lockstep
    assign done = &root_done;

endmodule

FILE: sv/sobel_edge_magnitude_rgb_unit.sv
// Top level: streaming per-channel 3x3 Sobel edge magnitude over two line stores.
//
//  channel | signals                          | payload
//  --------+----------------------------------+-----------------------------------
//  in      | s_axis_tvalid/tready/tdata       | blue, green, red
//  out     | m_axis_tvalid/tready/tdata/tlast | edge_blue, edge_green, edge_red
//  config  | cfg_we, cfg_index, cfg_data      | frame_width, frame_height
//
// A pixel with no result steps through accept, line store read and update.
// A pixel with one result also has its gradients squared into a register; the
// bit-serial root needs load, 8 steps and a finish, then the result drains.
// A pixel closing a row with two results runs the two roots in turn.
// Reset clears counters and window; stores are not cleared, border forcing
// keeps unwritten entries unread. A stalled output holds the sequencer;
// input is taken only when free.
module sobel_edge_magnitude_rgb_unit #(
    parameter int unsigned MAX_LINE_PIXELS = sem_pkg::MaxLinePixels
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // blue[7:0], green[15:8], red[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // edge_blue, edge_green, edge_red
    output logic        m_axis_tlast,   // frame_last
    input  logic        cfg_we,
    input  logic [sem_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int unsigned AddrWidth = $clog2(MAX_LINE_PIXELS);
    localparam int unsigned MaxCol    = MAX_LINE_PIXELS - 1;

    logic [10:0] width_reg;
    logic [11:0] height_reg;

    // line stores: one read-modify-write per pixel, packed {older, newer}
    logic [47:0] store_mem [MAX_LINE_PIXELS];
    logic [47:0] rd_reg;
    logic        store_we;
    logic [47:0] store_wd;

    sem_pkg::seq_state_t state_reg, state_next;
    logic [AddrWidth-1:0] col_reg, col_next;
    logic [11:0] row_reg, row_next;
    logic [23:0] pix_reg, pix_next;
    sem_pkg::column_t l1_reg, l1_next, l2_reg, l2_next;
    sem_pkg::column_t cur;

    logic [11:0] w_eff;
    logic [11:0] h_eff;
    logic        drain, last_col;

    sem_pkg::window_t win;
    logic        mag_start;
    logic        mag_done;
    logic [23:0] mag;
    logic        busy_reg, busy_next;
    logic        ovalid_reg, ovalid_next;
    logic [23:0] odata_reg, odata_next;
    logic        olast_reg, olast_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sem_pkg::FrameWidthReset;
            height_reg <= sem_pkg::FrameHeightReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sem_pkg::RegFrameWidth:  width_reg  <= cfg_data[10:0];
                sem_pkg::RegFrameHeight: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == 11'd0)
            w_eff = 12'd1;
        else if (32'(width_reg) > MAX_LINE_PIXELS)
            w_eff = 12'(MAX_LINE_PIXELS);
        else
            w_eff = {1'b0, width_reg};
        h_eff = (height_reg == 12'd0) ? 12'd1 : height_reg;
    end

    assign drain    = row_reg >= h_eff;
    assign last_col = {{(32-AddrWidth){1'b0}}, col_reg} >= 32'(w_eff) - 32'd1;

    always_comb
    begin
        cur.top = (row_reg >= 12'd2) ? rd_reg[47:24] : 24'd0;
        cur.mid = (row_reg >= 12'd1) ? rd_reg[23:0]  : 24'd0;
        cur.bot = pix_reg;
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[col_reg] <= store_wd;
        rd_reg <= store_mem[col_next];
    end

    always_comb
    begin
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        pix_next    = pix_reg;
        l1_next     = l1_reg;
        l2_next     = l2_reg;
        store_we    = 1'b0;
        store_wd    = {rd_reg[23:0], pix_reg};
        mag_start   = 1'b0;
        win         = '{left: l2_reg, center: l1_reg, right: cur, last: 1'b0};
        s_axis_tready = 1'b0;
        unique case (state_reg)
            sem_pkg::ST_TAKE:
            begin
                s_axis_tready = !busy_reg && !ovalid_reg;
                if (s_axis_tvalid && s_axis_tready)
                begin
                    pix_next   = drain ? 24'd0 : s_axis_tdata;
                    state_next = sem_pkg::ST_READ;
                end
            end
            sem_pkg::ST_READ:
            begin
                if (col_reg == '0)
                begin
                    l1_next = '0;
                    l2_next = '0;
                end
                state_next = sem_pkg::ST_EMIT1;
            end
            sem_pkg::ST_EMIT1:
            begin
                if (row_reg != 12'd0 && col_reg != '0)
                begin
                    mag_start  = 1'b1;
                    state_next = last_col ? sem_pkg::ST_EMIT2 : sem_pkg::ST_TAKE;
                end
                else if (row_reg != 12'd0 && last_col)
                    state_next = sem_pkg::ST_EMIT2;
                else
                    state_next = sem_pkg::ST_TAKE;
                if (row_reg == 12'd0 || !last_col)
                begin
                    store_we = 1'b1;
                    l2_next  = l1_reg;
                    l1_next  = cur;
                    if (last_col)
                    begin
                        col_next = '0;
                        row_next = drain ? 12'd0 : row_reg + 12'd1;
                    end
                    else
                        col_next = col_reg + 1'b1;
                end
            end
            sem_pkg::ST_EMIT2:
            begin
                win = '{left: l1_reg, center: cur, right: '0, last: drain};
                if (!busy_reg && !ovalid_reg)
                begin
                    mag_start  = 1'b1;
                    store_we   = 1'b1;
                    l2_next    = l1_reg;
                    l1_next    = cur;
                    col_next   = '0;
                    row_next   = drain ? 12'd0 : row_reg + 12'd1;
                    state_next = sem_pkg::ST_TAKE;
                end
            end
            default: state_next = sem_pkg::ST_TAKE;
        endcase
    end

    // end-of-frame flag of the request in flight
    logic last_hold_reg;

    always_comb
    begin
        busy_next   = busy_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;
        if (mag_start)
            busy_next = 1'b1;
        if (mag_done)
        begin
            busy_next   = 1'b0;
            ovalid_next = 1'b1;
            odata_next  = mag;
            olast_next  = last_hold_reg;
        end
    end

    sem_mag u_mag
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mag_start),
        .win   (win),
        .done  (mag_done),
        .mag   (mag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sem_pkg::ST_TAKE;
            col_reg    <= '0;
            row_reg    <= 12'd0;
            l1_reg     <= '0;
            l2_reg     <= '0;
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= (col_next > AddrWidth'(MaxCol)) ? AddrWidth'(MaxCol) : col_next;
            row_reg    <= row_next;
            l1_reg     <= l1_next;
            l2_reg     <= l2_next;
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg   <= pix_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
        if (mag_start)
            last_hold_reg <= win.last;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;

    // no input is taken while a result is being computed
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !s_axis_tready)
        else $error("input accepted while magnitude busy");

    // a new magnitude never starts over a pending one
    assert property (@(posedge clk) disable iff (!rst_n)
        mag_start |-> !busy_reg)
        else $error("magnitude restarted while busy");

    // completion only follows a started computation
    assert property (@(posedge clk) disable iff (!rst_n)
        mag_done |-> $past(busy_reg))
        else $error("magnitude done without start");

endmodule

FILE: tb/tb_top.sv
// Testbench for the streaming RGB Sobel edge magnitude unit: table-driven and random frames.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ClkHalf      = 2;
    localparam int unsigned CycleLimit   = 900000;
    localparam int unsigned SettleCycles = 60;     // idle period after the last result before a register write

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;    // blue[7:0], green[15:8], red[23:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;    // edge_blue[7:0], edge_green[15:8], edge_red[23:16]
    logic        m_axis_tlast;    // frame_last
    logic        cfg_we;
    logic [sem_pkg::CfgIndexWidth-1:0] cfg_index;
    logic [11:0] cfg_data;

    sobel_edge_magnitude_rgb_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // one edge result: three channel magnitudes plus the end-of-frame flag
    typedef struct packed {
        logic        last;
        logic [23:0] mags;
    } edge_px_t;

    // predictor state: its own copy of geometry, line stores and window
    logic [10:0] geo_width;
    logic [11:0] geo_height;
    logic [23:0] line_older [sem_pkg::MaxLinePixels];
    logic [23:0] line_newer [sem_pkg::MaxLinePixels];
    logic [23:0] win_near [3];     // column c-1, top/mid/bottom
    logic [23:0] win_far  [3];     // column c-2
    int unsigned col_pos;
    int unsigned row_pos;

    edge_px_t    edge_queue [$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned frames_seen;
    int unsigned cycle_count;
    bit          rx_hold;         // long receiver hold-off request
    bit          rx_hold_done;
    int unsigned requests_sent;
    bit          typed_on;        // table row with a typed result value
    logic [23:0] typed_value;

    // exact rounded integer root, clamped to 255
    function automatic logic [7:0] round_root(input int unsigned s);
        int unsigned n;
        int unsigned t;
        n = 0;
        if (s > sem_pkg::RootClampLimit)
            return 8'd255;
        for (int b = 7; b >= 0; b--)
        begin
            t = n | (1 << b);
            if (t * t <= s)
                n = t;
        end
        if (s > n * n + n)
            n++;
        return (n > 255) ? 8'd255 : n[7:0];
    endfunction

    function automatic int chan(input logic [23:0] px, input int unsigned ch);
        return int'(px[ch*8 +: 8]);
    endfunction

    function automatic logic [23:0] rand_px();
        return {8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255))};
    endfunction

    // Sobel over three columns l (left), m (middle), r (right), each top/mid/bot
    function automatic logic [23:0] sobel_rgb(input logic [23:0] l [3], input logic [23:0] m [3],
                                              input logic [23:0] r [3]);
        logic [23:0] res;
        int gx;
        int gy;
        for (int ch = 0; ch < 3; ch++)
        begin
            gx = (chan(r[0], ch) + 2 * chan(r[1], ch) + chan(r[2], ch))
               - (chan(l[0], ch) + 2 * chan(l[1], ch) + chan(l[2], ch));
            gy = (chan(l[2], ch) + 2 * chan(m[2], ch) + chan(r[2], ch))
               - (chan(l[0], ch) + 2 * chan(m[0], ch) + chan(r[0], ch));
            res[ch*8 +: 8] = round_root(gx * gx + gy * gy);
        end
        return res;
    endfunction

    function automatic void predictor_reset();
        geo_width  = sem_pkg::FrameWidthReset;
        geo_height = sem_pkg::FrameHeightReset;
        for (int k = 0; k < 3; k++)
        begin
            win_near[k] = '0;
            win_far[k]  = '0;
        end
        col_pos = 0;
        row_pos = 0;
    endfunction

    // advance the predictor by one accepted pixel, queueing its edge results
    function automatic void predict_edges(input logic [23:0] pixel);
        logic [23:0] cur [3];
        logic [23:0] near [3];
        logic [23:0] far [3];
        logic [23:0] zero3 [3];
        int unsigned w;
        int unsigned h;
        int unsigned c;
        bit drain;
        bit at_last;
        logic [23:0] px;
        edge_px_t ex;
        w = (geo_width == 0) ? 1 : ((geo_width > sem_pkg::MaxLinePixels) ?
                                    sem_pkg::MaxLinePixels : geo_width);
        h = (geo_height == 0) ? 1 : geo_height;
        c = (col_pos >= sem_pkg::MaxLinePixels) ? sem_pkg::MaxLinePixels - 1 : col_pos;
        drain   = row_pos >= h;
        at_last = c >= w - 1;
        px = drain ? 24'd0 : pixel;
        cur[0] = (row_pos >= 2) ? line_older[c] : 24'd0;
        cur[1] = (row_pos >= 1) ? line_newer[c] : 24'd0;
        cur[2] = px;
        for (int k = 0; k < 3; k++)
        begin
            near[k]  = (c == 0) ? 24'd0 : win_near[k];
            far[k]   = (c == 0) ? 24'd0 : win_far[k];
            zero3[k] = '0;
        end
        if (row_pos >= 1)
        begin
            if (c >= 1)
            begin
                ex.mags = sobel_rgb(far, near, cur);
                ex.last = 1'b0;
                edge_queue.push_back(ex);
            end
            if (at_last)
            begin
                ex.mags = sobel_rgb(near, cur, zero3);
                ex.last = drain;
                edge_queue.push_back(ex);
            end
        end
        line_older[c] = line_newer[c];
        line_newer[c] = px;
        for (int k = 0; k < 3; k++)
        begin
            win_far[k]  = near[k];
            win_near[k] = cur[k];
        end
        if (at_last)
        begin
            col_pos = 0;
            row_pos = drain ? 0 : ((row_pos + 1) & 12'hFFF);
        end
        else
            col_pos = c + 1;
    endfunction

    // random gap: mostly none or short, now and then long
    function automatic int unsigned idle_gap();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 55)
            return 0;
        if (p < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever
            #(ClkHalf) clk = ~clk;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("%0t: timeout after %0d cycles, %0d results pending", $time, cycle_count,
                     edge_queue.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // output check at the rising edge
    always @(posedge clk)
    begin
        edge_px_t exp_px;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (typed_on && m_axis_tdata !== typed_value)
            begin
                mismatches++;
                $display("%0t: table value expected %h actual %h", $time, typed_value,
                         m_axis_tdata);
            end
            if (edge_queue.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result data=%h last=%b", $time, m_axis_tdata,
                         m_axis_tlast);
            end
            else
            begin
                exp_px = edge_queue.pop_front();
                if (m_axis_tlast)
                    frames_seen++;
                if (m_axis_tdata[7:0] !== exp_px.mags[7:0])
                begin
                    mismatches++;
                    $display("%0t: edge_blue expected %0d actual %0d", $time,
                             exp_px.mags[7:0], m_axis_tdata[7:0]);
                end
                if (m_axis_tdata[15:8] !== exp_px.mags[15:8])
                begin
                    mismatches++;
                    $display("%0t: edge_green expected %0d actual %0d", $time,
                             exp_px.mags[15:8], m_axis_tdata[15:8]);
                end
                if (m_axis_tdata[23:16] !== exp_px.mags[23:16])
                begin
                    mismatches++;
                    $display("%0t: edge_red expected %0d actual %0d", $time,
                             exp_px.mags[23:16], m_axis_tdata[23:16]);
                end
                if (m_axis_tlast !== exp_px.last)
                begin
                    mismatches++;
                    $display("%0t: frame_last expected %b actual %b", $time, exp_px.last,
                             m_axis_tlast);
                end
            end
        end
    end

    // receiver: random stalls; one long hold-off counted here when requested
    initial
    begin
        int unsigned gap;
        m_axis_tready = 1'b0;
        rx_hold_done  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold && !rx_hold_done)
            begin
                m_axis_tready = 1'b0;
                repeat (400) @(negedge clk);
                rx_hold_done = 1'b1;
            end
            gap = idle_gap();
            if (gap == 0)
                m_axis_tready = 1'b1;
            else
            begin
                m_axis_tready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    end

    // hand one pixel over; predictor runs at the accepting edge
    task automatic send_pixel(input logic [23:0] px, input bit use_gaps);
        int unsigned gap;
        gap = use_gaps ? idle_gap() : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_edges(px);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic idle_sender();
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
    endtask

    // wait for every expected result, then a settle period before a register write
    task automatic drain_wait();
        idle_sender();
        while (edge_queue.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic write_reg(input logic [sem_pkg::CfgIndexWidth-1:0] idx,
                             input logic [11:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == sem_pkg::RegFrameWidth)
            geo_width = val[10:0];
        else
            geo_height = val;
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h);
        drain_wait();
        write_reg(sem_pkg::RegFrameWidth, w[11:0]);
        write_reg(sem_pkg::RegFrameHeight, h[11:0]);
    endtask

    // one full frame plus drain row; style picks the pixel content
    task automatic send_frame(input int unsigned w, input int unsigned h, input int unsigned style);
        logic [23:0] px;
        for (int unsigned r = 0; r <= h; r++)
            for (int unsigned c = 0; c < w; c++)
            begin
                case (style)
                    0: px = rand_px();
                    1: px = ($urandom_range(1)) ? 24'hFFFFFF : 24'h000000;
                    default: px = {8'(c * 37), 8'(r * 53), 8'($urandom_range(255))};
                endcase
                send_pixel(px, 1'b1);
            end
    endtask

    // directed table: geometry, pixel fill, and a typed expectation where obvious
    typedef struct {
        int unsigned w;
        int unsigned h;
        logic [23:0] fill;
        bit          typed;       // results all equal typed_mags
        logic [23:0] typed_mags;
    } dir_row_t;

    dir_row_t dir_rows [7] = '{
        // flat 1x1 bright pixel: every neighbor zero, gx=gy=0 -> 0
        '{1, 1, 24'hFFFFFF, 1'b1, 24'h000000},
        // 1x1 dark frame
        '{1, 1, 24'h000000, 1'b1, 24'h000000},
        // 2x2 full white: borders give clamped edges
        '{2, 2, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
        // single column, odd channel pattern
        '{1, 3, 24'h01807F, 1'b0, 24'h0},
        // single row
        '{5, 1, 24'hA55AFF, 1'b0, 24'h0},
        // width 0 acts as 1, height 0 acts as 1
        '{0, 0, 24'h123456, 1'b0, 24'h0},
        '{3, 2, 24'h000001, 1'b0, 24'h0}
    };

    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned q0;
        int unsigned weff;
        int unsigned heff;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = sem_pkg::RegFrameWidth;
        cfg_data      = '0;
        rst_n         = 1'b0;
        rx_hold       = 1'b0;
        typed_on      = 1'b0;
        typed_value   = '0;
        mismatches    = 0;
        results_seen  = 0;
        frames_seen   = 0;
        cycle_count   = 0;
        requests_sent = 0;
        predictor_reset();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset geometry is 640 wide: a few row-0 pixels give nothing; then the
        // width shrinks mid-row so the next pixel closes row 0, and height 1
        // makes row 1 the drain row
        for (int unsigned k = 0; k < 8; k++)
            send_pixel(rand_px(), 1'b0);
        set_geometry(8, 1);
        for (int unsigned k = 0; k < 9; k++)
            send_pixel(rand_px(), 1'b1);

        // directed table
        foreach (dir_rows[i])
        begin
            set_geometry(dir_rows[i].w, dir_rows[i].h);
            weff = (dir_rows[i].w == 0) ? 1 : dir_rows[i].w;
            heff = (dir_rows[i].h == 0) ? 1 : dir_rows[i].h;
            typed_value = dir_rows[i].typed_mags;
            typed_on    = dir_rows[i].typed;
            for (int unsigned k = 0; k < weff * (heff + 1); k++)
                send_pixel(dir_rows[i].fill, 1'b0);
            drain_wait();
            typed_on = 1'b0;
        end

        // largest register values, each cut short once a few pixels are in
        set_geometry(2047, 1);
        for (int unsigned k = 0; k < 3; k++)
            send_pixel(rand_px(), 1'b0);
        set_geometry(3, 1);
        for (int unsigned k = 0; k < 4; k++)
            send_pixel(rand_px(), 1'b0);
        set_geometry(2, 4095);
        for (int unsigned k = 0; k < 6; k++)
            send_pixel(rand_px(), 1'b0);
        set_geometry(2, 3);
        for (int unsigned k = 0; k < 2; k++)
            send_pixel(rand_px(), 1'b0);

        // back-pressure: receiver holds off while the sender keeps offering
        set_geometry(8, 6);
        rx_hold = 1'b1;
        send_frame(8, 6, 0);

        // random frames of small sizes for the bulk of the run
        q0 = requests_sent;
        while (requests_sent - q0 < 580)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 9);
            h = ($urandom_range(9) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 6);
            set_geometry(w, h);
            send_frame(w, h, $urandom_range(2));
        end

        drain_wait();
        $display("Covered %0d pixel requests, %0d edge results, %0d frame ends,", requests_sent,
                 results_seen, frames_seen);
        $display("frame shapes from 1x1 to 40 wide, geometry cut mid-frame, stalls on both sides.");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
sv/sem_pkg.sv
sv/sem_root.sv
sv/sem_mag.sv
sv/sobel_edge_magnitude_rgb_unit.sv
tb/tb_top.sv
